>>> design/sccb_master_controller_unit_macros.svh
// ----------------------------------------------------------------------------
// SCCB master controller assertion macros
// Shared concurrent check forms, clocked on clk, muted while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef SCCB_MASTER_CONTROLLER_UNIT_MACROS_SVH
`define SCCB_MASTER_CONTROLLER_UNIT_MACROS_SVH

// condition that must hold at every edge
`define SCCB_CHECK(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// consequence that must hold at the edge after the antecedent
`define SCCB_CHECK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/sccb_pkg.sv
// ----------------------------------------------------------------------------
// sccb_pkg
// Types, codes and sequencing functions of the SCCB master controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sccb_pkg;

	localparam int DELAY_WIDTH_DEF = 16;
	localparam int HBT_WIDTH       = 16;
	localparam logic [HBT_WIDTH-1:0] HBT_RESET = 16'd100;

	// request function codes
	localparam logic [1:0] FUNC_TICK  = 2'd0;
	localparam logic [1:0] FUNC_WRITE = 2'd1;
	localparam logic [1:0] FUNC_READ  = 2'd2;

	// item classes after the front end
	localparam logic [1:0] CLS_TICK  = 2'd0;
	localparam logic [1:0] CLS_WRITE = 2'd1;
	localparam logic [1:0] CLS_READ  = 2'd2;

	// bus operations
	localparam logic [3:0] OP_START  = 4'd0;
	localparam logic [3:0] OP_SADW   = 4'd1;
	localparam logic [3:0] OP_SADR   = 4'd2;
	localparam logic [3:0] OP_SREG   = 4'd3;
	localparam logic [3:0] OP_SDATA  = 4'd4;
	localparam logic [3:0] OP_ACKC   = 4'd5;
	localparam logic [3:0] OP_ACKI   = 4'd6;
	localparam logic [3:0] OP_STOP   = 4'd7;
	localparam logic [3:0] OP_RECV   = 4'd8;
	localparam logic [3:0] OP_NOACK  = 4'd9;
	localparam logic [3:0] OP_FINISH = 4'd10;

	// stop positions in the write and read sequences
	localparam logic [3:0] WR_STOP_POS = 4'd7;
	localparam logic [3:0] RD_STOP_POS = 4'd11;

	// transfer status
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BUS_BUSY = 2'd1;
	localparam logic [1:0] ST_START    = 2'd2;
	localparam logic [1:0] ST_NO_ACK   = 2'd3;

	// outcome of one bus action
	localparam logic [1:0] RES_GO   = 2'd0;
	localparam logic [1:0] RES_WAIT = 2'd1;
	localparam logic [1:0] RES_END  = 2'd2;

	typedef struct packed {
		logic [1:0] func;
		logic [6:0] slave_addr;
		logic [7:0] reg_addr;
		logic [7:0] write_data;
		logic       sda_level;
	} in_item_t;

	typedef struct packed {
		logic       scl_out;
		logic       sda_out;
		logic       sda_enable;
		logic       busy_res;
		logic       done_res;
		logic [1:0] status;
		logic [7:0] read_data;
	} out_item_t;

	typedef struct packed {
		logic [1:0] cls;
		logic [6:0] slave_addr;
		logic [7:0] reg_addr;
		logic [7:0] write_data;
		logic       sda_level;
	} q_item_t;

	typedef struct packed {
		logic       running;
		logic [3:0] seq_pos;
		logic [1:0] phase;
		logic [3:0] bit_count;
		logic [7:0] shift_byte;
		logic [6:0] held_slave;
		logic [7:0] held_reg;
		logic [7:0] held_data;
		logic       is_read;
		logic [7:0] last_read;
		logic [1:0] last_status;
		logic       scl;
		logic       sda;
		logic       en;
	} eng_t;

	typedef struct packed {
		eng_t       st;
		logic [1:0] res;
	} act_res_t;

	localparam eng_t ENG_RESET = '{
		running: 1'b0, seq_pos: 4'd0, phase: 2'd0, bit_count: 4'd0,
		shift_byte: 8'd0, held_slave: 7'd0, held_reg: 8'd0, held_data: 8'd0,
		is_read: 1'b0, last_read: 8'd0, last_status: ST_OK,
		scl: 1'b1, sda: 1'b1, en: 1'b1
	};

	function automatic logic [3:0] prog_op(input logic is_read, input logic [3:0] pos);
		logic [3:0] op;
		if (is_read) begin
			unique case (pos)
				4'd0:    op = OP_START;
				4'd1:    op = OP_SADW;
				4'd2:    op = OP_ACKC;
				4'd3:    op = OP_SREG;
				4'd4:    op = OP_ACKI;
				4'd5:    op = OP_STOP;
				4'd6:    op = OP_START;
				4'd7:    op = OP_SADR;
				4'd8:    op = OP_ACKC;
				4'd9:    op = OP_RECV;
				4'd10:   op = OP_NOACK;
				4'd11:   op = OP_STOP;
				default: op = OP_FINISH;
			endcase
		end else begin
			unique case (pos)
				4'd0:    op = OP_START;
				4'd1:    op = OP_SADW;
				4'd2:    op = OP_ACKC;
				4'd3:    op = OP_SREG;
				4'd4:    op = OP_ACKI;
				4'd5:    op = OP_SDATA;
				4'd6:    op = OP_ACKI;
				4'd7:    op = OP_STOP;
				default: op = OP_FINISH;
			endcase
		end
		return op;
	endfunction

	function automatic eng_t go_to(input eng_t s, input logic [3:0] pos);
		eng_t       r;
		logic [3:0] op;
		r           = s;
		r.seq_pos   = pos;
		r.phase     = 2'd0;
		r.bit_count = 4'd0;
		op          = prog_op(s.is_read, pos);
		unique case (op)
			OP_SADW:  r.shift_byte = {s.held_slave, 1'b0};
			OP_SADR:  r.shift_byte = {s.held_slave, 1'b1};
			OP_SREG:  r.shift_byte = s.held_reg;
			OP_SDATA: r.shift_byte = s.held_data;
			default:  r.shift_byte = 8'd0;
		endcase
		return r;
	endfunction

	// one pin action of the current operation
	function automatic act_res_t act(input eng_t s, input logic lvl);
		act_res_t   a;
		eng_t       r;
		logic [3:0] op;
		logic [3:0] nb;
		logic [3:0] nxt_pos;
		r       = s;
		a.res   = RES_WAIT;
		op      = prog_op(s.is_read, s.seq_pos);
		nb      = s.bit_count + 4'd1;
		nxt_pos = s.seq_pos + 4'd1;
		unique case (op)
			OP_START: begin
				if (s.phase == 2'd0) begin
					r.sda = 1'b1; r.en = 1'b1; r.scl = 1'b1; r.phase = 2'd1;
				end else if (s.phase == 2'd1) begin
					r.en = 1'b1;
					if (!lvl) begin
						r.last_status = ST_BUS_BUSY;
						a.res = RES_END;
					end else begin
						r.sda = 1'b0; r.phase = 2'd2;
					end
				end else begin
					r.scl = 1'b0;
					if (lvl) begin
						r.last_status = ST_START;
						a.res = RES_END;
					end else begin
						r = go_to(r, nxt_pos);
						a.res = RES_GO;
					end
				end
			end
			OP_SADW, OP_SADR, OP_SREG, OP_SDATA: begin
				if (s.phase == 2'd0) begin
					r.sda = s.shift_byte[7];
					r.shift_byte = {s.shift_byte[6:0], 1'b0};
					r.phase = 2'd1;
				end else if (s.phase == 2'd1) begin
					r.scl = 1'b1; r.phase = 2'd2;
				end else begin
					r.scl = 1'b0;
					r.bit_count = nb;
					if (nb >= 4'd8) r = go_to(r, nxt_pos);
					else r.phase = 2'd0;
					a.res = RES_GO;
				end
			end
			OP_ACKC, OP_ACKI: begin
				if (s.phase == 2'd0) begin
					r.scl = 1'b0; r.en = 1'b0; r.phase = 2'd1;
				end else if (s.phase == 2'd1) begin
					r.scl = 1'b1; r.phase = 2'd2;
				end else begin
					r.en = 1'b1; r.scl = 1'b0;
					if (op == OP_ACKC && lvl) begin
						r.last_status = ST_NO_ACK;
						r = go_to(r, s.is_read ? RD_STOP_POS : WR_STOP_POS);
					end else begin
						r = go_to(r, nxt_pos);
					end
					a.res = RES_GO;
				end
			end
			OP_STOP: begin
				if (s.phase == 2'd0) begin
					r.scl = 1'b0; r.sda = 1'b0; r.phase = 2'd1;
				end else if (s.phase == 2'd1) begin
					r.scl = 1'b1; r.phase = 2'd2;
				end else begin
					r.sda = 1'b1;
					r = go_to(r, nxt_pos);
				end
			end
			OP_RECV: begin
				if (s.phase == 2'd0) begin
					r.en = 1'b0; r.scl = 1'b0; r.phase = 2'd1;
				end else if (s.phase == 2'd1) begin
					r.scl = 1'b1; r.phase = 2'd2;
				end else begin
					r.shift_byte = {s.shift_byte[6:0], lvl};
					r.bit_count = nb;
					if (nb >= 4'd8) begin
						r.en = 1'b1; r.scl = 1'b0;
						r.last_read = r.shift_byte;
						r = go_to(r, nxt_pos);
					end else begin
						r.phase = 2'd0;
					end
					a.res = RES_GO;
				end
			end
			OP_NOACK: begin
				unique case (s.phase)
					2'd0: begin r.scl = 1'b0; r.phase = 2'd1; end
					2'd1: begin r.sda = 1'b1; r.phase = 2'd2; end
					2'd2: begin r.scl = 1'b1; r.phase = 2'd3; end
					default: begin
						r.scl = 1'b0;
						r = go_to(r, nxt_pos);
					end
				endcase
			end
			default: a.res = RES_END;
		endcase
		a.st = r;
		return a;
	endfunction

endpackage

>>> design/sccb_master_controller_unit.sv
// ----------------------------------------------------------------------------
// sccb_master_controller_unit
// SCCB master for single-register writes and reads, one bus step per item.
// ----------------------------------------------------------------------------
//  channel  | handshake        | payload
//  ---------+------------------+----------------------------------------
//  input    | push / full      | in_item  (func, addresses, data, SDA)
//  result   | pop / empty      | out_item (pins, busy, done, status, byte)
//  config   | cfg_we           | cfg_wdata (ticks per delay interval)
//
//  One item per clock sustained while the result queue has room; a result is on the result
//  ports once its item has passed the front queue and the engine step into the result queue.
//  The engine step (up to two chained pin actions) sets the cycle.
//  Reset clears both queues and returns the pins to SCL high, SDA driven high.
//  A held result stalls the engine only once the result queue is full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sccb_master_controller_unit #(
	parameter int DELAY_WIDTH = sccb_pkg::DELAY_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  sccb_pkg::in_item_t             in_item,
	output logic                           empty,
	input  logic                           pop,
	output sccb_pkg::out_item_t            out_item,
	input  logic                           cfg_we,
	input  logic [sccb_pkg::HBT_WIDTH-1:0] cfg_wdata
);
	import sccb_pkg::*;

	logic    q_valid;
	q_item_t q_item;
	logic    q_take;

	sccb_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.in_item (in_item),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_take  (q_take)
	);

	sccb_back #(
		.DELAY_WIDTH (DELAY_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_take    (q_take),
		.empty     (empty),
		.pop       (pop),
		.out_item  (out_item)
	);

endmodule

>>> design/sccb_front.sv
// ----------------------------------------------------------------------------
// sccb_front
// Takes input items, classifies them as tick, write or read, and holds them
// in a two-entry queue for the bus engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sccb_master_controller_unit_macros.svh"

module sccb_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  sccb_pkg::in_item_t in_item,
	output logic               q_valid,
	output sccb_pkg::q_item_t  q_item,
	input  logic               q_take
);
	import sccb_pkg::*;

	q_item_t    mem_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	q_item_t    cls_item;
	logic       acc;
	logic       take;

	always_comb begin
		cls_item.slave_addr = in_item.slave_addr;
		cls_item.reg_addr   = in_item.reg_addr;
		cls_item.write_data = in_item.write_data;
		cls_item.sda_level  = in_item.sda_level;
		unique case (in_item.func)
			FUNC_WRITE: cls_item.cls = CLS_WRITE;
			FUNC_READ:  cls_item.cls = CLS_READ;
			default:    cls_item.cls = CLS_TICK;
		endcase
	end

	assign full    = (cnt_q == 2'd2);
	assign q_valid = (cnt_q != 2'd0);
	assign q_item  = mem_q[rp_q];
	assign acc     = push && !full;
	assign take    = q_take && q_valid;

	always_ff @(posedge clk) begin
		if (acc) mem_q[wp_q] <= cls_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (acc) wp_q <= !wp_q;
			if (take) rp_q <= !rp_q;
			if (acc && !take) cnt_q <= cnt_q + 2'd1;
			else if (take && !acc) cnt_q <= cnt_q - 2'd1;
		end
	end

	`SCCB_CHECK(a_front_cnt_max, cnt_q <= 2'd2, "front queue count out of range")
	`SCCB_CHECK_NEXT(a_front_fill, acc && !take, cnt_q == $past(cnt_q) + 2'd1, "front fill lost")
	`SCCB_CHECK_NEXT(a_front_drain, take && !acc, cnt_q == $past(cnt_q) - 2'd1, "front drain lost")

endmodule

>>> design/sccb_back.sv
// ----------------------------------------------------------------------------
// sccb_back
// Bus engine: runs one timing step per queued item, drives the pin levels
// and pushes one result item per step into a two-entry result queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sccb_master_controller_unit_macros.svh"

module sccb_back #(
	parameter int DELAY_WIDTH = sccb_pkg::DELAY_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [sccb_pkg::HBT_WIDTH-1:0]     cfg_wdata,
	input  logic                               q_valid,
	input  sccb_pkg::q_item_t                  q_item,
	output logic                               q_take,
	output logic                               empty,
	input  logic                               pop,
	output sccb_pkg::out_item_t                out_item
);
	import sccb_pkg::*;

	localparam int CMP_W = (DELAY_WIDTH > HBT_WIDTH) ? DELAY_WIDTH : HBT_WIDTH;

	logic [HBT_WIDTH-1:0]   hbt_q;
	eng_t                   eng_q;
	logic [DELAY_WIDTH-1:0] tick_q;

	eng_t                   pre;
	eng_t                   nxt;
	logic [DELAY_WIDTH-1:0] tick_pre;
	logic [DELAY_WIDTH-1:0] tick_d;
	logic [DELAY_WIDTH-1:0] wait_val;
	logic [HBT_WIDTH-1:0]   dly;
	logic [CMP_W-1:0]       dly_ext;
	logic [CMP_W-1:0]       mask_ext;
	logic                   run;
	logic                   done_c;
	act_res_t               a1;
	act_res_t               a2;
	logic                   fire;
	out_item_t              res_item;

	out_item_t              mem_q [2];
	logic                   wp_q;
	logic                   rp_q;
	logic [1:0]             cnt_q;
	logic                   res_room;
	logic                   res_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) hbt_q <= HBT_RESET;
		else if (cfg_we) hbt_q <= cfg_wdata;
	end

	// interval reload: a zero register acts as one, long delays saturate
	always_comb begin
		dly      = (hbt_q == '0) ? '0 : hbt_q - 1'b1;
		dly_ext  = CMP_W'(dly);
		mask_ext = CMP_W'({DELAY_WIDTH{1'b1}});
		if (dly_ext > mask_ext) wait_val = mask_ext[DELAY_WIDTH-1:0];
		else wait_val = dly_ext[DELAY_WIDTH-1:0];
	end

	always_comb begin
		pre      = eng_q;
		tick_pre = tick_q;
		run      = 1'b0;
		if (!eng_q.running && (q_item.cls == CLS_WRITE || q_item.cls == CLS_READ)) begin
			pre.held_slave  = q_item.slave_addr;
			pre.held_reg    = q_item.reg_addr;
			pre.held_data   = q_item.write_data;
			pre.is_read     = (q_item.cls == CLS_READ);
			pre.last_status = ST_OK;
			pre.running     = 1'b1;
			tick_pre        = '0;
			pre             = go_to(pre, 4'd0);
			run             = 1'b1;
		end else if (eng_q.running) begin
			if (tick_q != '0) tick_pre = tick_q - 1'b1;
			else run = 1'b1;
		end
	end

	// at most two actions per tick: the last action of a bit or an operation, then
	// the first action of the next bit or operation, which always waits
	assign a1 = act(pre, q_item.sda_level);
	assign a2 = act(a1.st, q_item.sda_level);

	always_comb begin
		nxt    = pre;
		tick_d = tick_pre;
		done_c = 1'b0;
		if (run) begin
			unique case (a1.res)
				RES_WAIT: begin
					nxt    = a1.st;
					tick_d = wait_val;
				end
				RES_END: begin
					nxt         = a1.st;
					nxt.running = 1'b0;
					nxt.phase   = 2'd0;
					tick_d      = '0;
					done_c      = 1'b1;
				end
				default: begin
					nxt = a2.st;
					unique case (a2.res)
						RES_WAIT: tick_d = wait_val;
						RES_END: begin
							nxt.running = 1'b0;
							nxt.phase   = 2'd0;
							tick_d      = '0;
							done_c      = 1'b1;
						end
						default: ;
					endcase
				end
			endcase
		end
	end

	always_comb begin
		res_item.scl_out    = nxt.scl;
		res_item.sda_out    = nxt.sda;
		res_item.sda_enable = nxt.en;
		res_item.busy_res   = nxt.running;
		res_item.done_res   = done_c;
		res_item.status     = nxt.last_status;
		res_item.read_data  = nxt.last_read;
	end

	assign res_take = pop && (cnt_q != 2'd0);
	assign res_room = (cnt_q != 2'd2) || res_take;
	assign fire     = q_valid && res_room;
	assign q_take   = fire;
	assign empty    = (cnt_q == 2'd0);
	assign out_item = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eng_q  <= ENG_RESET;
			tick_q <= '0;
		end else if (fire) begin
			eng_q  <= nxt;
			tick_q <= tick_d;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) mem_q[wp_q] <= res_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (fire) wp_q <= !wp_q;
			if (res_take) rp_q <= !rp_q;
			if (fire && !res_take) cnt_q <= cnt_q + 2'd1;
			else if (res_take && !fire) cnt_q <= cnt_q - 2'd1;
		end
	end

	`SCCB_CHECK(a_back_cnt_max, cnt_q <= 2'd2, "result queue count out of range")
	`SCCB_CHECK(a_back_idle_tick, eng_q.running || tick_q == '0, "idle engine holds a delay")
	`SCCB_CHECK_NEXT(a_back_done_idle, fire && done_c, !eng_q.running, "engine busy after done")
	`SCCB_CHECK_NEXT(a_back_res_seen, fire, cnt_q != 2'd0, "result item lost")

endmodule
